[rtl/mcs_pkg.sv]
// ----------------------------------------------------------------------------
// mcs_pkg
// shared types, sizes and command codes of the motion clip sequencer
// ----------------------------------------------------------------------------
package mcs_pkg;

  localparam int NumClips  = 16;
  localparam int StepDepth = 1024;
  localparam int RingDepth = 8;

  localparam int ClipW  = $clog2(NumClips);
  localparam int StepAw = $clog2(StepDepth);
  localparam int RingAw = $clog2(RingDepth);
  localparam int CntW   = 10;

  localparam int CmdW     = 3;
  localparam int IdW      = 8;
  localparam int AddrW    = 10;
  localparam int PartW    = 8;
  localparam int AngleW   = 16;
  localparam int DurW     = 16;
  localparam int BaseW    = 10;
  localparam int LenW     = 8;
  localparam int CurClipW = 4;

  typedef enum logic [CmdW-1:0] {
    CmdTick      = 3'd0,
    CmdEnqueue   = 3'd1,
    CmdStopGrace = 3'd2,
    CmdStopNow   = 3'd3,
    CmdClearAll  = 3'd4,
    CmdPlayNow   = 3'd5,
    CmdWrStep    = 3'd6,
    CmdWrClip    = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [PartW-1:0]  part;
    logic [AngleW-1:0] angle;
    logic [DurW-1:0]   dur;
  } step_t;

  localparam int StepW = $bits(step_t);

  typedef struct packed {
    logic [BaseW-1:0] base;
    logic [LenW-1:0]  intro_len;
    logic [LenW-1:0]  loop_len;
    logic [LenW-1:0]  outro_len;
  } clip_t;

endpackage

[rtl/mcs_if.sv]
// ----------------------------------------------------------------------------
// mcs_if
// request and result channels of the motion clip sequencer
// ----------------------------------------------------------------------------
interface mcs_req_if;
  logic                          valid;
  logic                          ready;
  logic [mcs_pkg::CmdW-1:0]      cmd;
  logic [mcs_pkg::IdW-1:0]       clip_id;
  logic                          downstream_ready;
  logic [mcs_pkg::AddrW-1:0]     step_addr;
  logic [mcs_pkg::PartW-1:0]     wr_part;
  logic [mcs_pkg::AngleW-1:0]    wr_angle;
  logic [mcs_pkg::DurW-1:0]      wr_time;
  logic [mcs_pkg::BaseW-1:0]     wr_base;
  logic [mcs_pkg::LenW-1:0]      wr_intro_len;
  logic [mcs_pkg::LenW-1:0]      wr_loop_len;
  logic [mcs_pkg::LenW-1:0]      wr_outro_len;

  modport source (
    output valid, cmd, clip_id, downstream_ready, step_addr, wr_part, wr_angle,
           wr_time, wr_base, wr_intro_len, wr_loop_len, wr_outro_len,
    input  ready
  );
  modport sink (
    input  valid, cmd, clip_id, downstream_ready, step_addr, wr_part, wr_angle,
           wr_time, wr_base, wr_intro_len, wr_loop_len, wr_outro_len,
    output ready
  );
endinterface

interface mcs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          step_valid;
  logic [mcs_pkg::PartW-1:0]     step_part;
  logic [mcs_pkg::AngleW-1:0]    step_angle;
  logic [mcs_pkg::DurW-1:0]      step_time;
  logic                          cmd_ok;
  logic                          playing;
  logic [mcs_pkg::CurClipW-1:0]  current_clip;
  logic                          stopping;

  modport source (
    output valid, step_valid, step_part, step_angle, step_time, cmd_ok, playing,
           current_clip, stopping,
    input  ready
  );
  modport sink (
    input  valid, step_valid, step_part, step_angle, step_time, cmd_ok, playing,
           current_clip, stopping,
    output ready
  );
endinterface

[rtl/mcs_ram.sv]
// ----------------------------------------------------------------------------
// mcs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/motion_clip_sequencer.sv]
// ----------------------------------------------------------------------------
// motion_clip_sequencer
// plays servo motion clips (intro, loop, outro) out of a step memory
// ----------------------------------------------------------------------------
// One request is taken per clock cycle unless the output stalls. Each request
// gives exactly one result: the decision and all sequencer state updates
// happen in the cycle the request is taken, the step memory (single read port,
// registered read) is read in that same cycle, and the result passes the result
// stage and an output register. A result waiting at the output blocks the next
// request only once the result stage is full too; a step refused downstream is
// kept and offered again on the next tick. There is no clearing pass after
// reset: step memory and clip table contents are undefined until loaded by commands.
module motion_clip_sequencer (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcs_req_if.sink   req_i,
  mcs_rsp_if.source rsp_o
);

  typedef struct packed {
    logic                          valid;
    logic                          step_v;
    logic                          use_held;
    logic                          refused;
    logic                          ok;
    logic                          playing;
    logic [mcs_pkg::CurClipW-1:0]  clip;
    logic                          stopping;
  } s1_t;

  // sequencer state
  logic                              active_q, active_d;
  logic [mcs_pkg::ClipW-1:0]         clip_q, clip_d;
  logic [mcs_pkg::CntW-1:0]          cnt_q, cnt_d;
  logic                              grace_q, grace_d;
  logic                              retry_q, retry_d;
  logic [mcs_pkg::RingAw-1:0]        head_q, head_d;
  logic [mcs_pkg::RingAw-1:0]        tail_q, tail_d;
  logic [mcs_pkg::ClipW-1:0]         ring_q [mcs_pkg::RingDepth];
  mcs_pkg::clip_t                    clip_tab_q [mcs_pkg::NumClips];
  mcs_pkg::step_t                    held_q;

  // pipeline
  s1_t                               s1_q, s1_d;
  logic                              out_valid_q;
  mcs_pkg::step_t                    out_step_q;
  logic                              out_step_v_q;
  logic                              out_ok_q;
  logic                              out_playing_q;
  logic [mcs_pkg::CurClipW-1:0]      out_clip_q;
  logic                              out_stopping_q;

  logic                              in_fire;
  logic                              s1_adv;
  mcs_pkg::cmd_e                     cmd;
  mcs_pkg::clip_t                    cur;
  logic [mcs_pkg::LenW:0]            loop_end;
  logic [mcs_pkg::CntW-1:0]          clip_end;
  logic [mcs_pkg::CntW-1:0]          cnt_use;
  logic                              id_ok;
  logic [mcs_pkg::RingAw-1:0]        head_nxt;
  logic [mcs_pkg::RingAw-1:0]        tail_nxt;
  logic                              ring_we;
  logic                              clip_we;
  logic                              a_step_v;
  logic                              a_use_held;
  logic                              a_ok;

  logic                              ram_we;
  logic                              ram_re;
  logic [mcs_pkg::StepAw-1:0]        ram_raddr;
  mcs_pkg::step_t                    ram_wdata;
  logic [mcs_pkg::StepW-1:0]         ram_rdata;
  mcs_pkg::step_t                    s1_step;

  assign s1_adv       = !out_valid_q || rsp_o.ready;
  assign req_i.ready  = !s1_q.valid || s1_adv;
  assign in_fire      = req_i.valid && req_i.ready;
  assign cmd          = mcs_pkg::cmd_e'(req_i.cmd);

  assign cur      = clip_tab_q[clip_q];
  assign loop_end = {1'b0, cur.intro_len} + {1'b0, cur.loop_len};
  assign clip_end = mcs_pkg::CntW'(loop_end) + mcs_pkg::CntW'(cur.outro_len);
  assign id_ok    = 32'(req_i.clip_id) < mcs_pkg::NumClips;
  assign head_nxt = (32'(head_q) == mcs_pkg::RingDepth - 1) ? '0 : head_q + 1'b1;
  assign tail_nxt = (32'(tail_q) == mcs_pkg::RingDepth - 1) ? '0 : tail_q + 1'b1;

  assign ram_wdata.part  = req_i.wr_part;
  assign ram_wdata.angle = req_i.wr_angle;
  assign ram_wdata.dur   = req_i.wr_time;

  // request decode and state update
  always_comb begin
    active_d   = active_q;
    clip_d     = clip_q;
    cnt_d      = cnt_q;
    grace_d    = grace_q;
    retry_d    = retry_q;
    head_d     = head_q;
    tail_d     = tail_q;
    ring_we    = 1'b0;
    clip_we    = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    cnt_use    = cnt_q;
    ram_raddr  = mcs_pkg::StepAw'(cur.base + cnt_q);
    a_step_v   = 1'b0;
    a_use_held = 1'b0;
    a_ok       = 1'b0;
    if (in_fire) begin
      unique case (cmd)
        mcs_pkg::CmdTick: begin
          if (!active_q) begin
            if (head_q != tail_q) begin
              active_d = 1'b1;
              clip_d   = ring_q[tail_q];
              cnt_d    = '0;
              retry_d  = 1'b0;
              tail_d   = tail_nxt;
              a_ok     = 1'b1;
            end
          end else if (retry_q) begin
            a_step_v   = 1'b1;
            a_use_held = 1'b1;
          end else if (!grace_q && cur.loop_len == '0 &&
                       cnt_q == mcs_pkg::CntW'(cur.intro_len)) begin
            a_step_v = 1'b0;
          end else if (!grace_q && cnt_q == mcs_pkg::CntW'(loop_end)) begin
            cnt_use  = mcs_pkg::CntW'(cur.intro_len);
            a_step_v = 1'b1;
          end else if (cnt_q == clip_end) begin
            active_d = 1'b0;
            grace_d  = 1'b0;
            cnt_d    = '0;
            retry_d  = 1'b0;
          end else begin
            a_step_v = 1'b1;
          end
          if (a_step_v) begin
            retry_d = !req_i.downstream_ready;
            if (!a_use_held) begin
              ram_re    = 1'b1;
              ram_raddr = mcs_pkg::StepAw'(cur.base + cnt_use);
              cnt_d     = cnt_use + 1'b1;
            end
          end
        end
        mcs_pkg::CmdEnqueue: begin
          if (id_ok && head_nxt != tail_q) begin
            ring_we = 1'b1;
            head_d  = head_nxt;
            a_ok    = 1'b1;
          end
        end
        mcs_pkg::CmdStopGrace: begin
          grace_d = 1'b1;
        end
        mcs_pkg::CmdStopNow: begin
          active_d = 1'b0;
          grace_d  = 1'b0;
          cnt_d    = '0;
          retry_d  = 1'b0;
        end
        mcs_pkg::CmdClearAll: begin
          head_d   = tail_q;
          active_d = 1'b0;
          grace_d  = 1'b0;
          cnt_d    = '0;
          retry_d  = 1'b0;
        end
        mcs_pkg::CmdPlayNow: begin
          if (id_ok) begin
            active_d = 1'b1;
            clip_d   = mcs_pkg::ClipW'(req_i.clip_id);
            cnt_d    = '0;
            retry_d  = 1'b0;
            head_d   = tail_q;
            a_ok     = 1'b1;
          end
        end
        mcs_pkg::CmdWrStep: begin
          ram_we = 32'(req_i.step_addr) < mcs_pkg::StepDepth;
        end
        mcs_pkg::CmdWrClip: begin
          clip_we = id_ok;
        end
        default: begin
          a_ok = 1'b0;
        end
      endcase
    end
  end

  // request to result stage
  always_comb begin
    s1_d = s1_q;
    if (req_i.ready) begin
      s1_d.valid    = in_fire;
      s1_d.step_v   = a_step_v;
      s1_d.use_held = a_use_held;
      s1_d.refused  = a_step_v && !req_i.downstream_ready;
      s1_d.ok       = a_ok;
      s1_d.playing  = active_d;
      s1_d.clip     = active_d ? mcs_pkg::CurClipW'(clip_d) : '0;
      s1_d.stopping = grace_d;
    end
  end

  assign s1_step = s1_q.use_held ? held_q : mcs_pkg::step_t'(ram_rdata);

  mcs_ram #(
    .Width (mcs_pkg::StepW),
    .Depth (mcs_pkg::StepDepth)
  ) u_step_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (mcs_pkg::StepAw'(req_i.step_addr)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      clip_q      <= '0;
      cnt_q       <= '0;
      grace_q     <= 1'b0;
      retry_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      s1_q        <= '0;
      out_valid_q <= 1'b0;
      held_q      <= '0;
    end else begin
      active_q <= active_d;
      clip_q   <= clip_d;
      cnt_q    <= cnt_d;
      grace_q  <= grace_d;
      retry_q  <= retry_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      s1_q     <= s1_d;
      if (s1_adv) begin
        out_valid_q <= s1_q.valid;
        if (s1_q.valid && s1_q.refused) begin
          held_q <= s1_step;
        end
      end
    end
  end

  // storage without reset
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[head_q] <= mcs_pkg::ClipW'(req_i.clip_id);
    end
    if (clip_we) begin
      clip_tab_q[mcs_pkg::ClipW'(req_i.clip_id)] <= '{
        base:      req_i.wr_base,
        intro_len: req_i.wr_intro_len,
        loop_len:  req_i.wr_loop_len,
        outro_len: req_i.wr_outro_len
      };
    end
    if (s1_adv && s1_q.valid) begin
      out_step_v_q   <= s1_q.step_v;
      out_step_q     <= s1_q.step_v ? s1_step : '0;
      out_ok_q       <= s1_q.ok;
      out_playing_q  <= s1_q.playing;
      out_clip_q     <= s1_q.clip;
      out_stopping_q <= s1_q.stopping;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.step_valid   = out_step_v_q;
  assign rsp_o.step_part    = out_step_q.part;
  assign rsp_o.step_angle   = out_step_q.angle;
  assign rsp_o.step_time    = out_step_q.dur;
  assign rsp_o.cmd_ok       = out_ok_q;
  assign rsp_o.playing      = out_playing_q;
  assign rsp_o.current_clip = out_clip_q;
  assign rsp_o.stopping     = out_stopping_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the motion clip sequencer against a cycle-free model of its playback:
// loads the step memory and clip table, runs directed command cases, a ring
// full case, a long output stall and a weighted random command stream, with
// bursty requests and a stalling result sink
// ----------------------------------------------------------------------------
module testbench;
  import mcs_pkg::*;

  localparam int ResetCycles   = 12;
  localparam int MaxShown      = 10;
  localparam int DrainLimit    = 4000;
  localparam int HoldOffCycles = 300;
  localparam int PressureItems = 64;
  localparam int RandomItems   = 760;
  localparam int TimeoutNs     = 1_200_000;

  typedef struct {
    cmd_e             cmd;
    logic [IdW-1:0]   clip_id;
    logic             downstream_ready;
    logic [AddrW-1:0] step_addr;
    step_t            wr_step;
    clip_t            wr_clip;
  } play_request_t;

  typedef struct packed {
    logic                step_valid;
    logic [PartW-1:0]    part;
    logic [AngleW-1:0]   angle;
    logic [DurW-1:0]     dur;
    logic                cmd_ok;
    logic                playing;
    logic [CurClipW-1:0] clip;
    logic                stopping;
  } play_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mcs_req_if req_bus ();
  mcs_rsp_if rsp_bus ();

  motion_clip_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #1 clk_i = ~clk_i;

  // playback state of the model
  logic              clip_active;
  logic [ClipW-1:0]  clip_sel;
  logic [CntW-1:0]   step_cnt;
  logic              stop_due;
  logic              replay_due;
  step_t             held_step;
  clip_t             clip_tab [NumClips];
  step_t             step_mem [StepDepth];
  logic [ClipW-1:0]  id_ring [RingDepth];
  logic [RingAw-1:0] ring_wr;
  logic [RingAw-1:0] ring_rd;

  play_result_t play_results_due [$];
  play_result_t seen_result;
  int           mismatches = 0;
  int           burst_left = 0;
  bit           gaps_enabled = 1'b1;
  bit           stall_request = 1'b0;

  function automatic void begin_clip(input logic [ClipW-1:0] id);
    clip_active = 1'b1;
    clip_sel    = id;
    step_cnt    = '0;
    replay_due  = 1'b0;
  endfunction

  function automatic void halt_clip();
    clip_active = 1'b0;
    stop_due    = 1'b0;
    step_cnt    = '0;
    replay_due  = 1'b0;
  endfunction

  function automatic play_result_t predict_result(input play_request_t r);
    play_result_t      res;
    step_t             st;
    clip_t             info;
    int                loop_end;
    int                clip_end;
    logic [StepAw-1:0] rd_addr;
    bit                offer;
    res   = '0;
    st    = '0;
    offer = 1'b0;
    case (r.cmd)
      CmdTick: begin
        if (!clip_active) begin
          if (ring_wr != ring_rd) begin
            begin_clip(id_ring[ring_rd]);
            ring_rd = ring_rd + 1'b1;
            res.cmd_ok = 1'b1;
          end
        end else if (replay_due) begin
          st    = held_step;
          offer = 1'b1;
        end else begin
          info     = clip_tab[clip_sel];
          loop_end = int'(info.intro_len) + int'(info.loop_len);
          clip_end = loop_end + int'(info.outro_len);
          // a clip without loop holds after its intro until a graceful stop
          if (stop_due || info.loop_len != 0 || int'(step_cnt) != int'(info.intro_len)) begin
            if (!stop_due && int'(step_cnt) == loop_end) begin
              step_cnt = CntW'(info.intro_len);
              offer    = 1'b1;
            end else if (int'(step_cnt) == clip_end) begin
              halt_clip();
            end else begin
              offer = 1'b1;
            end
            if (offer) begin
              rd_addr  = info.base + StepAw'(step_cnt);
              st       = step_mem[rd_addr];
              step_cnt = step_cnt + 1'b1;
            end
          end
        end
        if (offer) begin
          replay_due = !r.downstream_ready;
          if (!r.downstream_ready) begin
            held_step = st;
          end
        end
      end
      CmdEnqueue: begin
        if (r.clip_id < NumClips && RingAw'(ring_wr + 1'b1) != ring_rd) begin
          id_ring[ring_wr] = r.clip_id[ClipW-1:0];
          ring_wr = ring_wr + 1'b1;
          res.cmd_ok = 1'b1;
        end
      end
      CmdStopGrace: stop_due = 1'b1;
      CmdStopNow:   halt_clip();
      CmdClearAll: begin
        ring_wr = ring_rd;
        halt_clip();
      end
      CmdPlayNow: begin
        if (r.clip_id < NumClips) begin
          begin_clip(r.clip_id[ClipW-1:0]);
          ring_wr = ring_rd;
          res.cmd_ok = 1'b1;
        end
      end
      CmdWrStep: step_mem[r.step_addr] = r.wr_step;
      default: begin
        if (r.clip_id < NumClips) begin
          clip_tab[r.clip_id[ClipW-1:0]] = r.wr_clip;
        end
      end
    endcase
    res.step_valid = offer;
    if (offer) begin
      res.part  = st.part;
      res.angle = st.angle;
      res.dur   = st.dur;
    end
    res.playing  = clip_active;
    res.clip     = clip_active ? clip_sel : '0;
    res.stopping = stop_due;
    return res;
  endfunction

  function automatic play_request_t make_request(input cmd_e cmd, input logic [IdW-1:0] id,
                                                 input logic ready);
    play_request_t r;
    r.cmd               = cmd;
    r.clip_id           = id;
    r.downstream_ready  = ready;
    r.step_addr         = AddrW'($urandom);
    r.wr_step.part      = PartW'($urandom);
    r.wr_step.angle     = AngleW'($urandom);
    r.wr_step.dur       = DurW'($urandom);
    r.wr_clip.base      = BaseW'($urandom);
    r.wr_clip.intro_len = LenW'($urandom);
    r.wr_clip.loop_len  = LenW'($urandom);
    r.wr_clip.outro_len = LenW'($urandom);
    return r;
  endfunction

  function automatic play_request_t random_request();
    play_request_t  r;
    int             pick;
    cmd_e           cmd;
    logic [IdW-1:0] id;
    pick = $urandom_range(0, 99);
    if (pick < 58)      cmd = CmdTick;
    else if (pick < 68) cmd = CmdEnqueue;
    else if (pick < 74) cmd = CmdStopGrace;
    else if (pick < 76) cmd = CmdStopNow;
    else if (pick < 78) cmd = CmdClearAll;
    else if (pick < 84) cmd = CmdPlayNow;
    else if (pick < 92) cmd = CmdWrStep;
    else                cmd = CmdWrClip;
    id = ($urandom_range(0, 9) == 0) ? IdW'($urandom_range(0, 255))
                                     : IdW'($urandom_range(0, NumClips - 1));
    r = make_request(cmd, id, $urandom_range(0, 4) != 0);
    // mostly short clips so that they run to their end
    if (cmd == CmdWrClip && $urandom_range(0, 7) != 0) begin
      r.wr_clip.intro_len = LenW'($urandom_range(0, 4));
      r.wr_clip.loop_len  = LenW'($urandom_range(0, 4));
      r.wr_clip.outro_len = LenW'($urandom_range(0, 4));
    end
    return r;
  endfunction

  function automatic string show_result(input play_result_t p);
    return $sformatf("valid=%0b part=%0h angle=%0h time=%0h ok=%0b playing=%0b clip=%0d stop=%0b",
                     p.step_valid, p.part, p.angle, p.dur, p.cmd_ok, p.playing, p.clip,
                     p.stopping);
  endfunction

  function automatic void note_mismatch(input string what, input play_result_t e,
                                        input play_result_t g);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("%0t %s", $time, what);
      $display("  expected %s", show_result(e));
      $display("  actual   %s", show_result(g));
    end
  endfunction

  task automatic send_request(input play_request_t r);
    int gap;
    if (gaps_enabled && burst_left == 0) begin
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    req_bus.valid            <= 1'b1;
    req_bus.cmd              <= r.cmd;
    req_bus.clip_id          <= r.clip_id;
    req_bus.downstream_ready <= r.downstream_ready;
    req_bus.step_addr        <= r.step_addr;
    req_bus.wr_part          <= r.wr_step.part;
    req_bus.wr_angle         <= r.wr_step.angle;
    req_bus.wr_time          <= r.wr_step.dur;
    req_bus.wr_base          <= r.wr_clip.base;
    req_bus.wr_intro_len     <= r.wr_clip.intro_len;
    req_bus.wr_loop_len      <= r.wr_clip.loop_len;
    req_bus.wr_outro_len     <= r.wr_clip.outro_len;
    @(posedge clk_i);
    while (req_bus.ready !== 1'b1) @(posedge clk_i);
    play_results_due.push_back(predict_result(r));
  endtask

  task automatic test_load_tables();
    play_request_t r;
    for (int a = 0; a < StepDepth; a++) begin
      r = make_request(CmdWrStep, IdW'($urandom), 1'($urandom));
      r.step_addr = AddrW'(a);
      if (a % 256 == 0) r.wr_step = '1;
      else if (a % 256 == 1) r.wr_step = '0;
      send_request(r);
    end
    for (int c = 0; c < NumClips; c++) begin
      r = make_request(CmdWrClip, IdW'(c), 1'b1);
      r.wr_clip.intro_len = LenW'($urandom_range(0, 3));
      r.wr_clip.loop_len  = LenW'($urandom_range(0, 3));
      r.wr_clip.outro_len = LenW'($urandom_range(0, 3));
      case (c)
        0:  r.wr_clip = '{base: 10'd100, intro_len: 8'd1, loop_len: 8'd1, outro_len: 8'd1};
        1:  r.wr_clip = '{base: 10'd200, intro_len: 8'd1, loop_len: 8'd0, outro_len: 8'd1};
        2:  r.wr_clip = '{base: 10'd1023, intro_len: 8'd1, loop_len: 8'd1, outro_len: 8'd1};
        15: r.wr_clip = '{base: 10'd0, intro_len: 8'd255, loop_len: 8'd255, outro_len: 8'd255};
        default: ;
      endcase
      send_request(r);
    end
  endtask

  task automatic test_directed_cases();
    play_request_t r;
    // refused ids and an ignored table write
    send_request(make_request(CmdEnqueue, 8'd255, 1'b1));
    send_request(make_request(CmdPlayNow, 8'd16, 1'b1));
    r = make_request(CmdWrClip, 8'd200, 1'b1);
    r.wr_clip = '1;
    send_request(r);
    // graceful stop while idle carries into the next clip, refused step re-offered
    send_request(make_request(CmdStopGrace, 8'd0, 1'b1));
    send_request(make_request(CmdEnqueue, 8'd0, 1'b1));
    send_request(make_request(CmdTick, 8'd0, 1'b1));
    send_request(make_request(CmdTick, 8'd0, 1'b0));
    repeat (4) send_request(make_request(CmdTick, 8'd0, 1'b1));
    // clip without loop holds, then plays its outro on a graceful stop
    send_request(make_request(CmdPlayNow, 8'd1, 1'b1));
    repeat (2) send_request(make_request(CmdTick, 8'd0, 1'b1));
    send_request(make_request(CmdStopGrace, 8'd0, 1'b1));
    repeat (2) send_request(make_request(CmdTick, 8'd0, 1'b1));
    // restart drops a refused step, step address wraps past the top
    send_request(make_request(CmdPlayNow, 8'd2, 1'b1));
    send_request(make_request(CmdTick, 8'd0, 1'b0));
    send_request(make_request(CmdPlayNow, 8'd2, 1'b1));
    repeat (2) send_request(make_request(CmdTick, 8'd0, 1'b1));
    send_request(make_request(CmdStopNow, 8'd0, 1'b1));
  endtask

  task automatic test_ring_full();
    for (int i = 0; i < RingDepth; i++) begin
      send_request(make_request(CmdEnqueue, IdW'($urandom_range(0, NumClips - 1)), 1'b1));
    end
    send_request(make_request(CmdClearAll, 8'd0, 1'b1));
  endtask

  task automatic test_output_backpressure();
    gaps_enabled  = 1'b0;
    stall_request = 1'b1;
    for (int i = 0; i < PressureItems; i++) begin
      send_request(random_request());
    end
    gaps_enabled = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RandomItems; i++) begin
      send_request(random_request());
    end
  endtask

  // result sink: long hold-off on request, otherwise a changing stall pattern
  initial begin
    int hold_left;
    int pattern_pos;
    bit take;
    hold_left   = 0;
    pattern_pos = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        hold_left     = HoldOffCycles;
        stall_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        pattern_pos++;
        case ((pattern_pos / 200) % 4)
          0:       take = 1'b1;
          1:       take = 1'($urandom_range(0, 1));
          2:       take = (pattern_pos % 8) >= 3;
          default: take = $urandom_range(0, 3) != 0;
        endcase
      end
      rsp_bus.ready <= take;
    end
  end

  always @(posedge clk_i) begin
    if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      seen_result = '{step_valid: rsp_bus.step_valid, part: rsp_bus.step_part,
                      angle: rsp_bus.step_angle, dur: rsp_bus.step_time,
                      cmd_ok: rsp_bus.cmd_ok, playing: rsp_bus.playing,
                      clip: rsp_bus.current_clip, stopping: rsp_bus.stopping};
      if (play_results_due.size() == 0) begin
        note_mismatch("result with no request waiting", '0, seen_result);
      end else if (seen_result !== play_results_due[0]) begin
        note_mismatch("result mismatch", play_results_due.pop_front(), seen_result);
      end else begin
        void'(play_results_due.pop_front());
      end
    end
  end

  initial begin
    int guard;
    rst_ni = 1'b0;
    req_bus.valid            <= 1'b0;
    req_bus.cmd              <= CmdTick;
    req_bus.clip_id          <= '0;
    req_bus.downstream_ready <= 1'b0;
    req_bus.step_addr        <= '0;
    req_bus.wr_part          <= '0;
    req_bus.wr_angle         <= '0;
    req_bus.wr_time          <= '0;
    req_bus.wr_base          <= '0;
    req_bus.wr_intro_len     <= '0;
    req_bus.wr_loop_len      <= '0;
    req_bus.wr_outro_len     <= '0;
    clip_active = 1'b0;
    clip_sel    = '0;
    step_cnt    = '0;
    stop_due    = 1'b0;
    replay_due  = 1'b0;
    held_step   = '0;
    ring_wr     = '0;
    ring_rd     = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_tables();
    test_directed_cases();
    test_ring_full();
    test_output_backpressure();
    test_random_traffic();
    req_bus.valid <= 1'b0;
    guard = 0;
    while (play_results_due.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (play_results_due.size() != 0) begin
      $display("%0d expected results never arrived", play_results_due.size());
      mismatches += play_results_due.size();
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
